// ===== design/gfm31_pkg.sv =====
package gfm31_pkg;

  localparam int unsigned PART_W = 31;
  localparam logic [PART_W-1:0] MOD_P = '1;
  localparam int unsigned NSB = 11;

  typedef enum logic [1:0] {
    OP_FWD  = 2'd0,
    OP_BWD  = 2'd1,
    OP_PSQ  = 2'd2,
    OP_R4SQ = 2'd3
  } op_t;

  typedef struct packed {
    logic [PART_W-1:0] re;
    logic [PART_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    op_t         req_type;
    logic [61:0] elem0;
    logic [61:0] elem1;
    logic [61:0] elem2;
    logic [61:0] elem3;
    logic [61:0] tw_a;
    logic [61:0] tw_b;
    logic [61:0] tw_c;
  } req_t;

  typedef struct packed {
    logic [61:0] out0;
    logic [61:0] out1;
    logic [61:0] out2;
    logic [61:0] out3;
  } rsp_t;

  typedef struct packed {
    logic  vld;
    op_t   op;
    cplx_t w;
  } side_t;

  localparam cplx_t C_ONE  = '{re: 31'd1, im: 31'd0};
  localparam cplx_t C_ZERO = '{re: 31'd0, im: 31'd0};

  function automatic logic [PART_W-1:0] canon(logic [PART_W-1:0] x);
    return (x == MOD_P) ? '0 : x;
  endfunction

  function automatic cplx_t unpack(logic [61:0] v);
    cplx_t z;
    z.re = canon(v[61:31]);
    z.im = canon(v[30:0]);
    return z;
  endfunction

  function automatic logic [PART_W-1:0] fadd(logic [PART_W-1:0] a, logic [PART_W-1:0] b);
    logic [PART_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return (t >= {1'b0, MOD_P}) ? PART_W'(t - {1'b0, MOD_P}) : t[PART_W-1:0];
  endfunction

  function automatic logic [PART_W-1:0] fsub(logic [PART_W-1:0] a, logic [PART_W-1:0] b);
    return (a >= b) ? (a - b) : (a + MOD_P - b);
  endfunction

  function automatic logic [PART_W-1:0] fold(logic [2*PART_W-1:0] t);
    return fadd(t[2*PART_W-1:PART_W], t[PART_W-1:0]);
  endfunction

  function automatic cplx_t cadd(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = fadd(a.re, b.re);
    r.im = fadd(a.im, b.im);
    return r;
  endfunction

  function automatic cplx_t csub(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = fsub(a.re, b.re);
    r.im = fsub(a.im, b.im);
    return r;
  endfunction

  function automatic cplx_t caddi(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = fsub(a.re, b.im);
    r.im = fadd(a.im, b.re);
    return r;
  endfunction

  function automatic cplx_t csubi(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = fadd(a.re, b.im);
    r.im = fsub(a.im, b.re);
    return r;
  endfunction

endpackage

// ===== design/gfm31_cmul.sv =====
module gfm31_cmul (
  input  logic            clk,
  input  gfm31_pkg::cplx_t x,
  input  gfm31_pkg::cplx_t y,
  input  logic            conj,
  output gfm31_pkg::cplx_t z
);
  import gfm31_pkg::*;

  logic [2*PART_W-1:0] rr;
  logic [2*PART_W-1:0] ii;
  logic [2*PART_W-1:0] ir;
  logic [2*PART_W-1:0] ri;
  logic                conj_q;
  logic [PART_W-1:0]   frr;
  logic [PART_W-1:0]   fii;
  logic [PART_W-1:0]   fir;
  logic [PART_W-1:0]   fri;
  cplx_t               z_next;

  always_ff @(posedge clk) begin
    rr     <= (2*PART_W)'(x.re) * (2*PART_W)'(y.re);
    ii     <= (2*PART_W)'(x.im) * (2*PART_W)'(y.im);
    ir     <= (2*PART_W)'(x.im) * (2*PART_W)'(y.re);
    ri     <= (2*PART_W)'(x.re) * (2*PART_W)'(y.im);
    conj_q <= conj;
  end

  always_comb begin
    frr = fold(rr);
    fii = fold(ii);
    fir = fold(ir);
    fri = fold(ri);
    if (conj_q) begin
      z_next.re = fadd(frr, fii);
      z_next.im = fsub(fir, fri);
    end else begin
      z_next.re = fsub(frr, fii);
      z_next.im = fadd(fir, fri);
    end
  end

  always_ff @(posedge clk) begin
    z <= z_next;
  end

endmodule

// ===== design/gf_mersenne31_sq_radix4_butterfly.sv =====
// throughput: one item per cycle; busy is always low
// four complex multiply layers of two stages each, plus three add stages
// the receiver cannot stall; each result is shown for exactly one cycle
// reset clears the valid bits only, dropping items in flight; otherwise no item is lost or repeated
module gf_mersenne31_sq_radix4_butterfly (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  gfm31_pkg::req_t req,
  output logic            done,
  output gfm31_pkg::rsp_t rsp
);
  import gfm31_pkg::*;

  side_t sb [NSB];
  side_t sb0_next;

  cplx_t u [4];
  cplx_t w1, w2, w3;
  cplx_t bt [4];
  cplx_t bv0, bv1, bv2, bv3;

  cplx_t m1x [4];
  cplx_t m1y [4];
  logic  m1c;
  cplx_t m1x_next [4];
  cplx_t m1y_next [4];
  logic  m1c_next;
  cplx_t m1o [4];

  cplx_t av0, av1, av2, av3;
  cplx_t az [4];
  cplx_t m2x [6];
  cplx_t m2y [6];
  cplx_t m2x_next [6];
  cplx_t m2y_next [6];
  cplx_t m2o [6];

  cplx_t m3x [4];
  cplx_t m3y [4];
  cplx_t m3o [4];
  cplx_t p2d [2];
  cplx_t p5d [2];

  cplx_t cz [4];
  cplx_t cy [4];
  logic  is_sq;
  cplx_t m4x [4];
  cplx_t m4y [4];
  cplx_t m4x_next [4];
  cplx_t m4y_next [4];
  cplx_t m4o [4];

  assign busy = 1'b0;

  // layer 1: unpack, backward adds, first multiply operands
  always_comb begin
    u[0] = unpack(req.elem0);
    u[1] = unpack(req.elem1);
    u[2] = unpack(req.elem2);
    u[3] = unpack(req.elem3);
    w1   = unpack(req.tw_a);
    w2   = unpack(req.tw_b);
    w3   = unpack(req.tw_c);
    bv0  = cadd(u[0], u[1]);
    bv1  = csub(u[0], u[1]);
    bv2  = cadd(u[2], u[3]);
    bv3  = csub(u[3], u[2]);
    bt[0] = cadd(bv0, bv2);
    bt[2] = csub(bv0, bv2);
    bt[1] = caddi(bv1, bv3);
    bt[3] = csubi(bv1, bv3);
    m1c_next = 1'b0;
    for (int k = 0; k < 4; k++) begin
      m1x_next[k] = u[k];
      m1y_next[k] = C_ONE;
    end
    case (req.req_type)
      OP_FWD: begin
        m1y_next[1] = w2;
        m1y_next[2] = w1;
        m1y_next[3] = w3;
      end
      OP_BWD: begin
        for (int k = 0; k < 4; k++) m1x_next[k] = bt[k];
        m1y_next[1] = w2;
        m1y_next[2] = w1;
        m1y_next[3] = w3;
        m1c_next    = 1'b1;
      end
      OP_R4SQ: begin
        m1y_next[2] = w1;
        m1y_next[3] = w1;
      end
      default: begin
      end
    endcase
    sb0_next.vld = start;
    sb0_next.op  = req.req_type;
    sb0_next.w   = w1;
  end

  always_ff @(posedge clk) begin
    m1x <= m1x_next;
    m1y <= m1y_next;
    m1c <= m1c_next;
    if (rst) begin
      for (int k = 0; k < NSB; k++) sb[k].vld <= 1'b0;
    end else begin
      sb[0] <= sb0_next;
      for (int k = 1; k < NSB; k++) sb[k] <= sb[k-1];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_m1
    gfm31_cmul u_mul (.clk(clk), .x(m1x[g]), .y(m1y[g]), .conj(m1c), .z(m1o[g]));
  end

  // layer 2: butterfly adds, square operands
  always_comb begin
    av0 = cadd(m1o[0], m1o[2]);
    av2 = csub(m1o[0], m1o[2]);
    av1 = cadd(m1o[1], m1o[3]);
    av3 = csub(m1o[1], m1o[3]);
    case (sb[2].op)
      OP_FWD: begin
        az[0] = cadd(av0, av1);
        az[1] = csub(av0, av1);
        az[2] = caddi(av2, av3);
        az[3] = csubi(av2, av3);
      end
      OP_R4SQ: begin
        az[0] = av0;
        az[1] = av1;
        az[2] = av2;
        az[3] = av3;
      end
      default: begin
        for (int k = 0; k < 4; k++) az[k] = m1o[k];
      end
    endcase
    if (sb[2].op == OP_PSQ || sb[2].op == OP_R4SQ) begin
      m2x_next[0] = az[0]; m2y_next[0] = az[0];
      m2x_next[1] = az[1]; m2y_next[1] = az[1];
      m2x_next[2] = az[0]; m2y_next[2] = az[1];
      m2x_next[3] = az[2]; m2y_next[3] = az[2];
      m2x_next[4] = az[3]; m2y_next[4] = az[3];
      m2x_next[5] = az[2]; m2y_next[5] = az[3];
    end else begin
      m2x_next[0] = az[0];  m2y_next[0] = C_ONE;
      m2x_next[1] = C_ZERO; m2y_next[1] = C_ZERO;
      m2x_next[2] = az[1];  m2y_next[2] = C_ONE;
      m2x_next[3] = az[2];  m2y_next[3] = C_ONE;
      m2x_next[4] = C_ZERO; m2y_next[4] = C_ZERO;
      m2x_next[5] = az[3];  m2y_next[5] = C_ONE;
    end
  end

  always_ff @(posedge clk) begin
    m2x <= m2x_next;
    m2y <= m2y_next;
  end

  for (genvar g = 0; g < 6; g++) begin : g_m2
    gfm31_cmul u_mul (.clk(clk), .x(m2x[g]), .y(m2y[g]), .conj(1'b0), .z(m2o[g]));
  end

  // layer 3: square of the odd terms times w
  always_comb begin
    m3x[0] = m2o[0]; m3y[0] = C_ONE;
    m3x[1] = m2o[1]; m3y[1] = sb[5].w;
    m3x[2] = m2o[3]; m3y[2] = C_ONE;
    m3x[3] = m2o[4]; m3y[3] = sb[5].w;
  end

  always_ff @(posedge clk) begin
    p2d[0] <= m2o[2];
    p2d[1] <= p2d[0];
    p5d[0] <= m2o[5];
    p5d[1] <= p5d[0];
  end

  for (genvar g = 0; g < 4; g++) begin : g_m3
    gfm31_cmul u_mul (.clk(clk), .x(m3x[g]), .y(m3y[g]), .conj(1'b0), .z(m3o[g]));
  end

  // layer 4: pair sums, backward radix-4 adds, conjugate twiddle
  always_comb begin
    is_sq = (sb[7].op == OP_PSQ) || (sb[7].op == OP_R4SQ);
    cz[0] = cadd(m3o[0], m3o[1]);
    cz[1] = is_sq ? cadd(p2d[1], p2d[1]) : p2d[1];
    cz[2] = csub(m3o[2], m3o[3]);
    cz[3] = is_sq ? cadd(p5d[1], p5d[1]) : p5d[1];
    if (sb[7].op == OP_R4SQ) begin
      cy[0] = cadd(cz[0], cz[2]);
      cy[1] = cadd(cz[1], cz[3]);
      cy[2] = csub(cz[0], cz[2]);
      cy[3] = csub(cz[1], cz[3]);
    end else begin
      for (int k = 0; k < 4; k++) cy[k] = cz[k];
    end
    for (int k = 0; k < 4; k++) begin
      m4x_next[k] = cy[k];
      m4y_next[k] = C_ONE;
    end
    if (sb[7].op == OP_R4SQ) begin
      m4y_next[2] = sb[7].w;
      m4y_next[3] = sb[7].w;
    end
  end

  always_ff @(posedge clk) begin
    m4x <= m4x_next;
    m4y <= m4y_next;
  end

  for (genvar g = 0; g < 4; g++) begin : g_m4
    gfm31_cmul u_mul (.clk(clk), .x(m4x[g]), .y(m4y[g]), .conj(1'b1), .z(m4o[g]));
  end

  assign done     = sb[NSB-1].vld;
  assign rsp.out0 = m4o[0];
  assign rsp.out1 = m4o[1];
  assign rsp.out2 = m4o[2];
  assign rsp.out3 = m4o[3];

endmodule
